// ===== rtl/core/afsf_pkg.sv =====
`timescale 1ns / 1ps

package afsf_pkg;

   // Default filter capacity in bytes
   localparam int MAX_FILTER_CHARS_DEF = 8;

   // Configuration register indexes
   localparam logic [1:0] CSR_FILTER_CHARS  = 2'd0;
   localparam logic [1:0] CSR_FILTER_LENGTH = 2'd1;

   // Lead byte of the accented Latin-1 vowels in UTF-8
   localparam logic [7:0] LEAD_BYTE = 8'hC3;

   // Result of folding one byte
   typedef struct packed {
      logic       ch_valid;
      logic [6:0] ch;
      logic       lead_next;
   } fold_type;

endpackage

// ===== rtl/core/afsf_fold.sv =====
`timescale 1ns / 1ps

module afsf_fold (
   input  logic [7:0]        name_byte,
   input  logic              last_byte,
   input  logic              lead_pending,
   output afsf_pkg::fold_type fold
);
   import afsf_pkg::*;

   // Plain lowercase vowel for the second byte of a lead pair, zero if none
   function automatic logic [6:0] vowel_of(input logic [7:0] b);
      logic [6:0] v;
      v = 7'h00;
      case (b)
         8'hA9, 8'hA8, 8'hAA, 8'hAB, 8'h89, 8'h8A, 8'h8B, 8'h88: v = 7'h65; // e
         8'hA0, 8'hA4, 8'hA2, 8'h80, 8'h84, 8'h82:               v = 7'h61; // a
         8'hB2, 8'hB6, 8'hB4, 8'h92, 8'h96, 8'h94:               v = 7'h6F; // o
         8'hAC, 8'hAF, 8'hAE, 8'h8C, 8'h8F, 8'h8E:               v = 7'h69; // i
         8'hB9, 8'hBC, 8'hBB, 8'h99, 8'h9C, 8'h9B:               v = 7'h75; // u
         default:                                                v = 7'h00;
      endcase
      return v;
   endfunction

   logic [6:0] vowel;
   logic       is_upper;
   logic       is_lower;
   logic       is_digit;
   logic [7:0] lowered;

   assign vowel    = vowel_of(name_byte);
   assign is_upper = (name_byte >= 8'h41) && (name_byte <= 8'h5A);
   assign is_lower = (name_byte >= 8'h61) && (name_byte <= 8'h7A);
   assign is_digit = (name_byte >= 8'h30) && (name_byte <= 8'h39);
   assign lowered  = name_byte + 8'h20;

   // Complete a pending pair, else examine the byte fresh
   always_comb begin
      fold = '0;
      if (lead_pending && (vowel != 7'h00)) begin
         fold.ch_valid = 1'b1;
         fold.ch       = vowel;
      end else if (is_upper) begin
         fold.ch_valid = 1'b1;
         fold.ch       = lowered[6:0];
      end else if (is_lower || is_digit) begin
         fold.ch_valid = 1'b1;
         fold.ch       = name_byte[6:0];
      end else if ((name_byte == LEAD_BYTE) && !last_byte) begin
         fold.lead_next = 1'b1;
      end
   end

endmodule

// ===== rtl/core/afsf_match.sv =====
`timescale 1ns / 1ps

module afsf_match (
   input  logic [3:0]  position,
   input  logic [3:0]  filter_len,
   input  logic [63:0] filter_chars,
   input  logic        ch_valid,
   input  logic [6:0]  ch,
   output logic [3:0]  position_next
);

   logic [7:0] want;

   // Select the next filter byte to look for
   assign want = filter_chars[{position[2:0], 3'b000} +: 8];

   // Advance on a match while filter bytes remain
   always_comb begin
      position_next = position;
      if (ch_valid && (position < filter_len) && (want == {1'b0, ch})) begin
         position_next = position + 4'd1;
      end
   end

endmodule

// ===== rtl/core/accent_fold_subsequence_filter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  req_name_byte, req_last_byte
// rsp       out        rsp_valid / rsp_ready  rsp_char_valid, rsp_folded_char,
//                                             rsp_name_done, rsp_accepted
// csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// One byte per cycle: a transfer on req yields its result in the rsp register
// on the next cycle; fold and filter step fit between the name state and that
// register. req_ready drops only while a result waits and rsp_ready is low.
// Reset clears the name state, the filter registers and the result valid.
// csr_ready is always high; writes take effect on the next byte.

module accent_fold_subsequence_filter #(
   parameter int MAX_FILTER_CHARS = afsf_pkg::MAX_FILTER_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_name_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_char_valid,
   output logic [6:0]  rsp_folded_char,
   output logic        rsp_name_done,
   output logic        rsp_accepted,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);
   import afsf_pkg::*;

   localparam logic [3:0] MAX_LEN = 4'(MAX_FILTER_CHARS);

   // Two-dot tracking codes
   localparam logic [1:0] DD_NONE = 2'd0;
   localparam logic [1:0] DD_ONE  = 2'd1;
   localparam logic [1:0] DD_TWO  = 2'd2;
   localparam logic [1:0] DD_NOT  = 2'd3;

   logic [63:0] filter_chars_ff;
   logic [3:0]  filter_length_ff;
   logic        lead_ff,  lead_in;
   logic [3:0]  pos_ff,   pos_in;
   logic [1:0]  dd_ff,    dd_in;
   logic        rsp_valid_ff;
   logic        char_valid_ff, char_valid_in;
   logic [6:0]  char_ff,  char_in;
   logic        done_ff,  done_in;
   logic        acc_ff,   acc_in;
   logic        req_fire;
   logic [3:0]  len_eff;
   logic [3:0]  pos_step;
   fold_type    fold;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign len_eff   = (filter_length_ff > MAX_LEN) ? MAX_LEN : filter_length_ff;

   afsf_fold u_fold (
      .name_byte    (req_name_byte),
      .last_byte    (req_last_byte),
      .lead_pending (lead_ff),
      .fold         (fold)
   );

   afsf_match u_match (
      .position      (pos_ff),
      .filter_len    (len_eff),
      .filter_chars  (filter_chars_ff),
      .ch_valid      (fold.ch_valid),
      .ch            (fold.ch),
      .position_next (pos_step)
   );

   // Next name state and result fields
   always_comb begin
      unique case (dd_ff)
         DD_NONE: dd_in = (req_name_byte == 8'h2E) ? DD_ONE : DD_NOT;
         DD_ONE:  dd_in = (req_name_byte == 8'h2E) ? DD_TWO : DD_NOT;
         default: dd_in = DD_NOT;
      endcase
      lead_in       = fold.lead_next;
      pos_in        = pos_step;
      char_valid_in = fold.ch_valid;
      char_in       = fold.ch;
      done_in       = req_last_byte;
      acc_in        = 1'b0;
      if (req_last_byte) begin
         acc_in  = (pos_step >= len_eff) || (dd_in == DD_TWO);
         lead_in = 1'b0;
         pos_in  = 4'd0;
         dd_in   = DD_NONE;
      end
   end

   // Hold filter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_chars_ff  <= '0;
         filter_length_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FILTER_CHARS:  filter_chars_ff  <= csr_data;
            CSR_FILTER_LENGTH: filter_length_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Advance name state on each input transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff <= 1'b0;
         pos_ff  <= '0;
         dd_ff   <= DD_NONE;
      end else if (req_fire) begin
         lead_ff <= lead_in;
         pos_ff  <= pos_in;
         dd_ff   <= dd_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_valid_ff <= char_valid_in;
         char_ff       <= char_in;
         done_ff       <= done_in;
         acc_ff        <= acc_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_valid  = char_valid_ff;
   assign rsp_folded_char = char_ff;
   assign rsp_name_done   = done_ff;
   assign rsp_accepted    = acc_ff;

`ifndef ASSERT_OFF
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_last_byte) |=> (pos_ff == 4'd0 && dd_ff == DD_NONE && !lead_ff))
      else $error("name state not cleared after last byte");

   a_accept_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_name_done) |-> !rsp_accepted)
      else $error("acceptance outside last byte");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_char_valid) |-> (rsp_folded_char == 7'd0))
      else $error("folded char set without char valid");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= MAX_LEN)
      else $error("filter position beyond capacity");
`endif

endmodule
